>>> hdl/tsfla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsfla_pkg
// Shared constants, types and codes of the tiered slice free-list allocator.
// ----------------------------------------------------------------------------
package tsfla_pkg;

  localparam int TierN      = 4;
  localparam int TierW      = 2;
  localparam int SlotN      = 1024;
  localparam int SlotW      = 10;
  localparam int IdxW       = TierW + SlotW;
  localparam int CntW       = 11;
  localparam int CapW       = 16;
  localparam int ReqW       = 32;
  localparam int ChainLimit = 64;
  localparam int ChainW     = 7;
  localparam int SeqAW      = 6;
  localparam int CfgN       = 8;
  localparam int CfgAW      = 3;

  typedef logic [TierN-1:0][CapW-1:0]  cap_vec_t;
  typedef logic [TierN-1:0][CntW-1:0]  cnt_vec_t;
  typedef logic [TierN-1:0][SlotW-1:0] slot_vec_t;

  typedef enum logic [1:0] {
    CMD_FORMAT  = 2'd0,
    CMD_ALLOC   = 2'd1,
    CMD_RECYCLE = 2'd2,
    CMD_CHAIN   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_BUF  = 2'd1,
    ST_BAD_HDL = 2'd2,
    ST_IDLE_SL = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_POP_RD,
    S_POP,
    S_SEQ_RD,
    S_SEQ_GET,
    S_REC_RD,
    S_REC,
    S_PLAN
  } state_e;

  typedef struct packed {
    logic             hit;
    logic [TierW-1:0] tier;
  } pick_t;

endpackage

>>> hdl/tiered_slice_free_list_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiered_slice_free_list_allocator_unit
// Buffer manager with four tiers of fixed-size slices on linked free lists.
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low; command_i picks
// format, allocate, recycle or allocate chain. Results come out one per cycle
// at most, each marked by done_o for one cycle; last_of_run_o flags the final
// one. The receiver cannot stall, so results are never held back.
// Tier sizes and counts are written on the cfg port (valid/ready, always
// ready) and take effect at the next format.
// Allocate passes S_POP_RD and S_POP, recycle S_REC_RD and S_REC; a refused
// allocate or a bad handle is answered from S_IDLE. Allocate chain plans one
// slice per cycle on the shared tier picker while a tier fits, stepping down a
// tier when none fits, then pops each slice through S_SEQ_RD, S_SEQ_GET,
// S_POP_RD and S_POP via the link memory's registered read port. Format sweeps
// all 4096 slots of the link and busy memories, one per cycle, then answers.
// After reset the block runs the same sweep to clear the busy marks with busy_o
// high; no tier is present until a format.
// ----------------------------------------------------------------------------
module tiered_slice_free_list_allocator_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [1:0]                          command_i,
  input  logic [tsfla_pkg::ReqW-1:0]          request_bytes_i,
  input  logic [tsfla_pkg::TierW-1:0]         handle_tier_i,
  input  logic [tsfla_pkg::SlotW-1:0]         handle_slot_i,
  output logic                                done_o,
  output logic [1:0]                          status_o,
  output logic [tsfla_pkg::TierW-1:0]         granted_tier_o,
  output logic [tsfla_pkg::SlotW-1:0]         granted_slot_o,
  output logic [tsfla_pkg::CapW-1:0]          granted_bytes_o,
  output logic                                last_of_run_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tsfla_pkg::CfgAW-1:0]         cfg_index_i,
  input  logic [tsfla_pkg::CapW-1:0]          cfg_data_i
);

  tsfla_pkg::state_e state_q, state_d;
  logic [tsfla_pkg::CapW-1:0] cfg_q [tsfla_pkg::CfgN];

  tsfla_pkg::cap_vec_t  cap_q, cap_d;
  tsfla_pkg::cnt_vec_t  cnt_q, cnt_d;
  tsfla_pkg::cnt_vec_t  free_q, free_d;
  tsfla_pkg::cnt_vec_t  fv_q, fv_d;
  tsfla_pkg::slot_vec_t head_q, head_d;
  tsfla_pkg::slot_vec_t tail_q, tail_d;

  logic [tsfla_pkg::IdxW-1:0]   idx_q, idx_d;
  logic                         fmt_q, fmt_d;
  logic                         chain_q, chain_d;
  logic [tsfla_pkg::TierW-1:0]  g_q, g_d;
  logic [tsfla_pkg::TierW-1:0]  t_q, t_d;
  logic [tsfla_pkg::ChainW-1:0] k_q, k_d;
  logic [tsfla_pkg::ChainW-1:0] n_q, n_d;
  logic [tsfla_pkg::ReqW-1:0]   rem_q, rem_d;
  logic [tsfla_pkg::TierW-1:0]  ht_q, ht_d;
  logic [tsfla_pkg::SlotW-1:0]  hs_q, hs_d;

  logic                         out_valid_q, out_valid_d;
  logic [1:0]                   out_status_q, out_status_d;
  logic [tsfla_pkg::TierW-1:0]  out_tier_q, out_tier_d;
  logic [tsfla_pkg::SlotW-1:0]  out_slot_q, out_slot_d;
  logic [tsfla_pkg::CapW-1:0]   out_bytes_q, out_bytes_d;
  logic                         out_last_q, out_last_d;

  logic                         link_we;
  logic [tsfla_pkg::IdxW-1:0]   link_waddr, link_raddr;
  logic [tsfla_pkg::SlotW-1:0]  link_wdata, link_rdata;
  logic                         busy_we;
  logic [tsfla_pkg::IdxW-1:0]   busy_waddr, busy_raddr;
  logic [0:0]                   busy_wdata, busy_rdata;
  logic                         seq_we;
  logic [tsfla_pkg::SeqAW-1:0]  seq_waddr, seq_raddr;
  logic [tsfla_pkg::TierW-1:0]  seq_wdata, seq_rdata;

  logic [tsfla_pkg::ReqW-1:0]   pick_size;
  tsfla_pkg::cnt_vec_t          pick_free;
  tsfla_pkg::pick_t             pick;

  logic [tsfla_pkg::TierW-1:0]  sw_tier;
  logic [tsfla_pkg::SlotW-1:0]  sw_slot;
  logic [tsfla_pkg::CntW-1:0]   sw_next;
  logic [tsfla_pkg::CapW-1:0]   cap_g;
  logic [tsfla_pkg::CapW-1:0]   lat_cap;
  logic [tsfla_pkg::CntW-1:0]   lat_cnt;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tsfla_pkg::CfgN; i++) begin
        cfg_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      if (cfg_index_i < tsfla_pkg::CfgAW'(tsfla_pkg::TierN)) begin
        cfg_q[cfg_index_i] <= cfg_data_i;
      end else begin
        cfg_q[cfg_index_i] <= {{(tsfla_pkg::CapW - tsfla_pkg::CntW){1'b0}},
                               cfg_data_i[tsfla_pkg::CntW-1:0]};
      end
    end
  end

  // shared picker: request size when idle, tier capacity while planning
  assign pick_size = (state_q == tsfla_pkg::S_PLAN) ?
                     {{(tsfla_pkg::ReqW - tsfla_pkg::CapW){1'b0}}, cap_q[t_q]} :
                     request_bytes_i;
  assign pick_free = (state_q == tsfla_pkg::S_PLAN) ? fv_q : free_q;

  tsfla_pick u_pick (
    .size_i (pick_size),
    .cap_i  (cap_q),
    .cnt_i  (cnt_q),
    .free_i (pick_free),
    .pick_o (pick)
  );

  tsfla_ram #(.Width(tsfla_pkg::SlotW), .Depth(tsfla_pkg::TierN * tsfla_pkg::SlotN)) u_link (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  tsfla_ram #(.Width(1), .Depth(tsfla_pkg::TierN * tsfla_pkg::SlotN)) u_busy (
    .clk_i   (clk_i),
    .we_i    (busy_we),
    .waddr_i (busy_waddr),
    .wdata_i (busy_wdata),
    .raddr_i (busy_raddr),
    .rdata_o (busy_rdata)
  );

  tsfla_ram #(.Width(tsfla_pkg::TierW), .Depth(tsfla_pkg::ChainLimit)) u_seq (
    .clk_i   (clk_i),
    .we_i    (seq_we),
    .waddr_i (seq_waddr),
    .wdata_i (seq_wdata),
    .raddr_i (seq_raddr),
    .rdata_o (seq_rdata)
  );

  assign sw_tier    = idx_q[tsfla_pkg::IdxW-1:tsfla_pkg::SlotW];
  assign sw_slot    = idx_q[tsfla_pkg::SlotW-1:0];
  assign sw_next    = {1'b0, sw_slot} + tsfla_pkg::CntW'(1);
  assign cap_g      = cap_q[g_q];
  assign link_raddr = {g_q, head_q[g_q]};
  assign busy_raddr = {ht_q, hs_q};
  assign seq_raddr  = k_q[tsfla_pkg::SeqAW-1:0];
  assign seq_waddr  = n_q[tsfla_pkg::SeqAW-1:0];
  assign seq_wdata  = pick.tier;

  always_comb begin
    state_d      = state_q;
    cap_d        = cap_q;
    cnt_d        = cnt_q;
    free_d       = free_q;
    fv_d         = fv_q;
    head_d       = head_q;
    tail_d       = tail_q;
    idx_d        = idx_q;
    fmt_d        = fmt_q;
    chain_d      = chain_q;
    g_d          = g_q;
    t_d          = t_q;
    k_d          = k_q;
    n_d          = n_q;
    rem_d        = rem_q;
    ht_d         = ht_q;
    hs_d         = hs_q;
    out_valid_d  = 1'b0;
    out_status_d = tsfla_pkg::ST_OK;
    out_tier_d   = '0;
    out_slot_d   = '0;
    out_bytes_d  = '0;
    out_last_d   = 1'b1;
    link_we      = 1'b0;
    link_waddr   = idx_q;
    link_wdata   = '0;
    busy_we      = 1'b0;
    busy_waddr   = idx_q;
    busy_wdata   = 1'b0;
    seq_we       = 1'b0;
    lat_cap      = '0;
    lat_cnt      = '0;

    case (state_q)
      tsfla_pkg::S_CLEAR: begin
        busy_we = 1'b1;
        if ({1'b0, sw_slot} < cnt_q[sw_tier]) begin
          link_we    = 1'b1;
          link_wdata = (sw_next == cnt_q[sw_tier]) ? '0 : sw_next[tsfla_pkg::SlotW-1:0];
        end
        idx_d = idx_q + tsfla_pkg::IdxW'(1);
        if (idx_q == '1) begin
          state_d     = tsfla_pkg::S_IDLE;
          fmt_d       = 1'b0;
          out_valid_d = fmt_q;
        end
      end

      tsfla_pkg::S_IDLE: begin
        if (start_i) begin
          case (command_i)
            tsfla_pkg::CMD_FORMAT: begin
              for (int t = 0; t < tsfla_pkg::TierN; t++) begin
                lat_cap = cfg_q[t] & 16'hFFFC;
                lat_cnt = cfg_q[t + tsfla_pkg::TierN][tsfla_pkg::CntW-1:0];
                if (lat_cnt > tsfla_pkg::CntW'(tsfla_pkg::SlotN)) begin
                  lat_cnt = tsfla_pkg::CntW'(tsfla_pkg::SlotN);
                end
                if (lat_cap == '0) begin
                  lat_cnt = '0;
                end
                cap_d[t]  = lat_cap;
                cnt_d[t]  = lat_cnt;
                free_d[t] = lat_cnt;
                head_d[t] = '0;
                tail_d[t] = (lat_cnt != '0) ?
                            tsfla_pkg::SlotW'(lat_cnt - tsfla_pkg::CntW'(1)) : '0;
              end
              fmt_d   = 1'b1;
              idx_d   = '0;
              state_d = tsfla_pkg::S_CLEAR;
            end
            tsfla_pkg::CMD_ALLOC: begin
              if (pick.hit) begin
                g_d     = pick.tier;
                chain_d = 1'b0;
                state_d = tsfla_pkg::S_POP_RD;
              end else begin
                out_valid_d  = 1'b1;
                out_status_d = tsfla_pkg::ST_NO_BUF;
              end
            end
            tsfla_pkg::CMD_RECYCLE: begin
              if (cap_q[handle_tier_i] == '0 || cnt_q[handle_tier_i] == '0 ||
                  {1'b0, handle_slot_i} >= cnt_q[handle_tier_i]) begin
                out_valid_d  = 1'b1;
                out_status_d = tsfla_pkg::ST_BAD_HDL;
              end else begin
                ht_d    = handle_tier_i;
                hs_d    = handle_slot_i;
                state_d = tsfla_pkg::S_REC_RD;
              end
            end
            default: begin
              rem_d   = request_bytes_i;
              n_d     = '0;
              k_d     = '0;
              t_d     = tsfla_pkg::TierW'(tsfla_pkg::TierN - 1);
              fv_d    = free_q;
              chain_d = 1'b1;
              state_d = tsfla_pkg::S_PLAN;
            end
          endcase
        end
      end

      tsfla_pkg::S_PLAN: begin
        if (rem_q == '0 || n_q == tsfla_pkg::ChainW'(tsfla_pkg::ChainLimit) ||
            (!pick.hit && t_q == '0)) begin
          if (rem_q != '0 || n_q == '0) begin
            out_valid_d  = 1'b1;
            out_status_d = tsfla_pkg::ST_NO_BUF;
            state_d      = tsfla_pkg::S_IDLE;
          end else begin
            k_d     = '0;
            state_d = tsfla_pkg::S_SEQ_RD;
          end
        end else if (!pick.hit) begin
          t_d = t_q - tsfla_pkg::TierW'(1);
        end else begin
          seq_we           = 1'b1;
          fv_d[pick.tier]  = fv_q[pick.tier] - tsfla_pkg::CntW'(1);
          n_d              = n_q + tsfla_pkg::ChainW'(1);
          if (rem_q > {{(tsfla_pkg::ReqW - tsfla_pkg::CapW){1'b0}}, cap_q[pick.tier]}) begin
            rem_d = rem_q - {{(tsfla_pkg::ReqW - tsfla_pkg::CapW){1'b0}}, cap_q[pick.tier]};
          end else begin
            rem_d = '0;
          end
        end
      end

      tsfla_pkg::S_SEQ_RD: begin
        state_d = tsfla_pkg::S_SEQ_GET;
      end

      tsfla_pkg::S_SEQ_GET: begin
        g_d     = seq_rdata;
        state_d = tsfla_pkg::S_POP_RD;
      end

      tsfla_pkg::S_POP_RD: begin
        state_d = tsfla_pkg::S_POP;
      end

      tsfla_pkg::S_POP: begin
        head_d[g_q]  = link_rdata;
        busy_we      = 1'b1;
        busy_waddr   = {g_q, head_q[g_q]};
        busy_wdata   = 1'b1;
        free_d[g_q]  = free_q[g_q] - tsfla_pkg::CntW'(1);
        out_valid_d  = 1'b1;
        out_tier_d   = g_q;
        out_slot_d   = head_q[g_q];
        out_bytes_d  = cap_g;
        out_last_d   = !chain_q || (k_q + tsfla_pkg::ChainW'(1) == n_q);
        if (out_last_d) begin
          state_d = tsfla_pkg::S_IDLE;
        end else begin
          k_d     = k_q + tsfla_pkg::ChainW'(1);
          state_d = tsfla_pkg::S_SEQ_RD;
        end
      end

      tsfla_pkg::S_REC_RD: begin
        state_d = tsfla_pkg::S_REC;
      end

      tsfla_pkg::S_REC: begin
        out_valid_d = 1'b1;
        state_d     = tsfla_pkg::S_IDLE;
        if (!busy_rdata[0]) begin
          out_status_d = tsfla_pkg::ST_IDLE_SL;
        end else begin
          busy_we      = 1'b1;
          busy_waddr   = {ht_q, hs_q};
          busy_wdata   = 1'b0;
          link_we      = 1'b1;
          link_waddr   = {ht_q, tail_q[ht_q]};
          link_wdata   = hs_q;
          tail_d[ht_q] = hs_q;
          free_d[ht_q] = free_q[ht_q] + tsfla_pkg::CntW'(1);
        end
      end

      default: begin
        state_d = tsfla_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tsfla_pkg::S_CLEAR;
      cap_q       <= '0;
      cnt_q       <= '0;
      free_q      <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      idx_q       <= '0;
      fmt_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cap_q       <= cap_d;
      cnt_q       <= cnt_d;
      free_q      <= free_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      idx_q       <= idx_d;
      fmt_q       <= fmt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fv_q         <= fv_d;
    chain_q      <= chain_d;
    g_q          <= g_d;
    t_q          <= t_d;
    k_q          <= k_d;
    n_q          <= n_d;
    rem_q        <= rem_d;
    ht_q         <= ht_d;
    hs_q         <= hs_d;
    out_status_q <= out_status_d;
    out_tier_q   <= out_tier_d;
    out_slot_q   <= out_slot_d;
    out_bytes_q  <= out_bytes_d;
    out_last_q   <= out_last_d;
  end

  assign busy_o          = (state_q != tsfla_pkg::S_IDLE);
  assign done_o          = out_valid_q;
  assign status_o        = out_status_q;
  assign granted_tier_o  = out_tier_q;
  assign granted_slot_o  = out_slot_q;
  assign granted_bytes_o = out_bytes_q;
  assign last_of_run_o   = out_last_q;

  // an accepted request either starts work or answers at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || done_o))
    else $error("request neither started nor answered");

  // refusals are always single results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != tsfla_pkg::ST_OK) |-> last_of_run_o)
    else $error("refusal not flagged last");

  // free counts never exceed formatted counts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_q[0] <= cnt_q[0]) && (free_q[1] <= cnt_q[1]) &&
    (free_q[2] <= cnt_q[2]) && (free_q[3] <= cnt_q[3]))
    else $error("free count above slice count");

endmodule

>>> hdl/tsfla_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsfla_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tsfla_ram #(
  parameter int Width = 1,
  parameter int Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/tsfla_pick.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsfla_pick
// Shared tier picker: first tier in index order that is present, fits the
// size and holds more than one free slice.
// ----------------------------------------------------------------------------
module tsfla_pick (
  input  logic [tsfla_pkg::ReqW-1:0] size_i,
  input  tsfla_pkg::cap_vec_t        cap_i,
  input  tsfla_pkg::cnt_vec_t        cnt_i,
  input  tsfla_pkg::cnt_vec_t        free_i,
  output tsfla_pkg::pick_t           pick_o
);

  always_comb begin
    pick_o = '0;
    for (int t = tsfla_pkg::TierN - 1; t >= 0; t--) begin
      if (size_i != '0 && cap_i[t] != '0 && cnt_i[t] != '0 &&
          size_i <= {{(tsfla_pkg::ReqW - tsfla_pkg::CapW){1'b0}}, cap_i[t]} &&
          free_i[t] > tsfla_pkg::CntW'(1)) begin
        pick_o.hit  = 1'b1;
        pick_o.tier = tsfla_pkg::TierW'(t);
      end
    end
  end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for tiered_slice_free_list_allocator_unit.
// ----------------------------------------------------------------------------
// A directed table walks through refusals, bad and idle handles, the size
// extremes and chains. Random phases follow, each with its own set of tier
// sizes and counts and a rate of sender gaps of 0, 20 or 46 percent. A
// behavioural copy of the four free lists predicts every grant, and each
// done_o strobe is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

  localparam int TierN      = tsfla_pkg::TierN;
  localparam int TierW      = tsfla_pkg::TierW;
  localparam int SlotN      = tsfla_pkg::SlotN;
  localparam int SlotW      = tsfla_pkg::SlotW;
  localparam int IdxW       = tsfla_pkg::IdxW;
  localparam int CntW       = tsfla_pkg::CntW;
  localparam int CapW       = tsfla_pkg::CapW;
  localparam int ReqW       = tsfla_pkg::ReqW;
  localparam int ChainLimit = tsfla_pkg::ChainLimit;
  localparam int CfgN       = tsfla_pkg::CfgN;
  localparam int CfgAW      = tsfla_pkg::CfgAW;

  localparam int IdleLimit = 20000;

  typedef struct packed {
    logic [1:0]      status;
    logic [TierW-1:0] tier;
    logic [SlotW-1:0] slot;
    logic [CapW-1:0]  bytes;
    logic            last;
  } grant_t;

  typedef struct packed {
    tsfla_pkg::cmd_e    cmd;
    logic [ReqW-1:0]    req;
    logic [TierW-1:0]   ht;
    logic [SlotW-1:0]   hs;
    bit                 fixed;
    tsfla_pkg::status_e st;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [1:0] command = '0;
  logic [ReqW-1:0] request_bytes = '0;
  logic [TierW-1:0] handle_tier = '0;
  logic [SlotW-1:0] handle_slot = '0;
  logic cfg_valid = 1'b0;
  logic [CfgAW-1:0] cfg_index = '0;
  logic [CapW-1:0] cfg_data = '0;
  logic busy, done, last_of_run, cfg_ready;
  logic [1:0] status;
  logic [TierW-1:0] granted_tier;
  logic [SlotW-1:0] granted_slot;
  logic [CapW-1:0] granted_bytes;

  tiered_slice_free_list_allocator_unit uut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .command_i(command), .request_bytes_i(request_bytes),
    .handle_tier_i(handle_tier), .handle_slot_i(handle_slot),
    .done_o(done), .status_o(status), .granted_tier_o(granted_tier),
    .granted_slot_o(granted_slot), .granted_bytes_o(granted_bytes),
    .last_of_run_o(last_of_run), .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // behavioural copy of the allocator
  logic [CapW-1:0]  reg_bytes [TierN];
  logic [CntW-1:0]  reg_count [TierN];
  logic [CapW-1:0]  slice_cap [TierN];
  logic [CntW-1:0]  tier_slices [TierN];
  logic [SlotW-1:0] link_mem [TierN*SlotN];
  bit               in_use [TierN*SlotN];
  logic [SlotW-1:0] head [TierN];
  logic [SlotW-1:0] tail [TierN];
  int unsigned      free_cnt [TierN];
  logic [IdxW-1:0]  held_slices [$];

  grant_t expected_grants [$];
  int errors = 0;
  int requests_taken = 0;
  int grants_seen = 0;
  int refusals_seen = 0;
  int idle_cycles = 0;
  int gap_pct = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void expect_grant(grant_t g);
    expected_grants.insert(expected_grants.size(), g);
  endfunction

  function automatic int fitting_tier(longint unsigned size, int unsigned fv [TierN]);
    for (int t = 0; t < TierN; t++) begin
      if (size != 0 && slice_cap[t] != 0 && tier_slices[t] != 0 &&
          size <= slice_cap[t] && fv[t] > 1) return t;
    end
    return TierN;
  endfunction

  function automatic grant_t take_head(int t, bit last);
    grant_t g;
    logic [SlotW-1:0] s;
    s = head[t];
    head[t] = link_mem[t*SlotN + s];
    in_use[t*SlotN + s] = 1'b1;
    free_cnt[t]--;
    held_slices.insert(held_slices.size(), {t[TierW-1:0], s});
    g = '{tsfla_pkg::ST_OK, t[TierW-1:0], s, slice_cap[t], last};
    return g;
  endfunction

  function automatic void format_tiers();
    int n;
    for (int t = 0; t < TierN; t++) begin
      n = reg_count[t] > SlotN ? SlotN : int'(reg_count[t]);
      if (reg_bytes[t][CapW-1:2] == 0) n = 0;
      slice_cap[t] = {reg_bytes[t][CapW-1:2], 2'b00};
      tier_slices[t] = n[CntW-1:0];
      for (int i = 0; i < SlotN; i++) in_use[t*SlotN + i] = 1'b0;
      for (int i = 0; i + 1 < n; i++) link_mem[t*SlotN + i] = SlotW'(i + 1);
      if (n != 0) link_mem[t*SlotN + n - 1] = '0;
      head[t] = '0;
      tail[t] = n != 0 ? SlotW'(n - 1) : '0;
      free_cnt[t] = n;
    end
    held_slices.delete();
  endfunction

  function automatic void predict_allocator(row_t r);
    grant_t g;
    int t;
    int n;
    int plan [ChainLimit];
    int unsigned fv [TierN];
    longint unsigned left;
    g = '{tsfla_pkg::ST_NO_BUF, '0, '0, '0, 1'b1};
    case (r.cmd)
      tsfla_pkg::CMD_FORMAT: begin
        format_tiers();
        g.status = tsfla_pkg::ST_OK;
        expect_grant(g);
      end
      tsfla_pkg::CMD_ALLOC: begin
        t = fitting_tier(r.req, free_cnt);
        if (t < TierN) g = take_head(t, 1'b1);
        expect_grant(g);
      end
      tsfla_pkg::CMD_RECYCLE: begin
        if (slice_cap[r.ht] == 0 || tier_slices[r.ht] == 0 ||
            r.hs >= tier_slices[r.ht]) begin
          g.status = tsfla_pkg::ST_BAD_HDL;
        end else if (!in_use[r.ht*SlotN + r.hs]) begin
          g.status = tsfla_pkg::ST_IDLE_SL;
        end else begin
          in_use[r.ht*SlotN + r.hs] = 1'b0;
          link_mem[r.ht*SlotN + tail[r.ht]] = r.hs;
          tail[r.ht] = r.hs;
          free_cnt[r.ht]++;
          g.status = tsfla_pkg::ST_OK;
          foreach (held_slices[i])
            if (held_slices[i] == {r.ht, r.hs}) begin
              held_slices.delete(i);
              break;
            end
        end
        expect_grant(g);
      end
      default: begin
        fv = free_cnt;
        left = r.req;
        n = 0;
        for (int k = TierN - 1; k >= 0 && left > 0; k--) begin
          forever begin
            if (n >= ChainLimit) break;
            t = fitting_tier(slice_cap[k], fv);
            if (t >= TierN) break;
            fv[t]--;
            plan[n] = t;
            n++;
            left = left > slice_cap[t] ? left - slice_cap[t] : 0;
            if (left == 0) break;
          end
        end
        if (r.req == 0 || left > 0 || n == 0) expect_grant(g);
        else for (int k = 0; k < n; k++) expect_grant(take_head(plan[k], k == n - 1));
      end
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    grant_t got, want;
    if (done) begin
      got = '{status, granted_tier, granted_slot, granted_bytes, last_of_run};
      if (expected_grants.size() == 0) begin
        $display("%0t: unexpected result status=%0d tier=%0d slot=%0d bytes=%0d last=%0b",
                 $time, status, granted_tier, granted_slot, granted_bytes, last_of_run);
        errors++;
      end else begin
        want = expected_grants.pop_front();
        if (got != want) begin
          $display("%0t: mismatch expected status=%0d tier=%0d slot=%0d bytes=%0d last=%0b",
                   $time, want.status, want.tier, want.slot, want.bytes, want.last);
          $display("%0t:          actual   status=%0d tier=%0d slot=%0d bytes=%0d last=%0b",
                   $time, got.status, got.tier, got.slot, got.bytes, got.last);
          errors++;
        end
        if (got.status == tsfla_pkg::ST_OK && got.bytes != 0) grants_seen++;
        if (got.status != tsfla_pkg::ST_OK) refusals_seen++;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (done || (start && !busy) || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: timeout, %0d results still expected", $time, expected_grants.size());
      $display("[tiered_slice_free_list_allocator_unit] ERROR");
      $finish;
    end
  end

  task automatic send_request(row_t r);
    if (gap_pct != 0)
      while ($urandom_range(99) < gap_pct) begin
        @(negedge clk);
        start = 1'b0;
      end
    @(negedge clk);
    start = 1'b1;
    command = r.cmd;
    request_bytes = r.req;
    handle_tier = r.ht;
    handle_slot = r.hs;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    requests_taken++;
    predict_allocator(r);
    if (r.fixed) begin
      expected_grants.delete(expected_grants.size() - 1);
      expect_grant('{r.st, '0, '0, '0, 1'b1});
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (350) @(posedge clk);
  endtask

  task automatic write_tiers(logic [CapW-1:0] b [TierN], logic [CntW-1:0] c [TierN]);
    for (int i = 0; i < CfgN; i++) begin
      @(negedge clk);
      cfg_valid = 1'b1;
      cfg_index = CfgAW'(i);
      cfg_data = i < TierN ? b[i] : CapW'(c[i-TierN]);
      if (i < TierN) reg_bytes[i] = b[i];
      else reg_count[i-TierN] = c[i-TierN];
      forever begin
        @(posedge clk);
        if (cfg_ready) break;
      end
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic row_t random_request();
    row_t r;
    int pick;
    logic [IdxW-1:0] h;
    r = '{tsfla_pkg::CMD_ALLOC, '0, '0, '0, 1'b0, tsfla_pkg::ST_OK};
    pick = $urandom_range(99);
    if (pick < 40) begin
      r.cmd = tsfla_pkg::CMD_ALLOC;
      r.req = $urandom_range(9) == 0 ? $urandom() : $urandom_range(70000);
    end else if (pick < 75) begin
      r.cmd = tsfla_pkg::CMD_RECYCLE;
      if (held_slices.size() != 0 && $urandom_range(4) != 0) begin
        pick = $urandom_range(held_slices.size() - 1);
        h = held_slices[pick];
        {r.ht, r.hs} = h;
      end else begin
        r.ht = TierW'($urandom());
        r.hs = SlotW'($urandom());
      end
    end else if (pick < 99) begin
      r.cmd = tsfla_pkg::CMD_CHAIN;
      r.req = $urandom_range(9) == 0 ? $urandom() : $urandom_range(300000);
    end else begin
      r.cmd = tsfla_pkg::CMD_FORMAT;
    end
    return r;
  endfunction

  initial begin
    row_t dir_rows [22] = '{
      '{tsfla_pkg::CMD_ALLOC,   32'd1,        2'd0, 10'd0,    1'b1, tsfla_pkg::ST_NO_BUF},
      '{tsfla_pkg::CMD_RECYCLE, 32'd0,        2'd0, 10'd0,    1'b1, tsfla_pkg::ST_BAD_HDL},
      '{tsfla_pkg::CMD_CHAIN,   32'd5,        2'd0, 10'd0,    1'b1, tsfla_pkg::ST_NO_BUF},
      '{tsfla_pkg::CMD_FORMAT,  32'd0,        2'd0, 10'd0,    1'b1, tsfla_pkg::ST_OK},
      '{tsfla_pkg::CMD_ALLOC,   32'd0,        2'd0, 10'd0,    1'b1, tsfla_pkg::ST_NO_BUF},
      '{tsfla_pkg::CMD_CHAIN,   32'd0,        2'd0, 10'd0,    1'b1, tsfla_pkg::ST_NO_BUF},
      '{tsfla_pkg::CMD_ALLOC,   32'd1,        2'd0, 10'd0,    1'b0, tsfla_pkg::ST_OK},
      '{tsfla_pkg::CMD_ALLOC,   32'd64,       2'd0, 10'd0,    1'b0, tsfla_pkg::ST_OK},
      '{tsfla_pkg::CMD_ALLOC,   32'd65,       2'd0, 10'd0,    1'b0, tsfla_pkg::ST_OK},
      '{tsfla_pkg::CMD_ALLOC,   32'd1024,     2'd0, 10'd0,    1'b0, tsfla_pkg::ST_OK},
      '{tsfla_pkg::CMD_ALLOC,   32'd65532,    2'd0, 10'd0,    1'b0, tsfla_pkg::ST_OK},
      '{tsfla_pkg::CMD_ALLOC,   32'd65533,    2'd0, 10'd0,    1'b1, tsfla_pkg::ST_NO_BUF},
      '{tsfla_pkg::CMD_ALLOC,   32'hFFFFFFFF, 2'd0, 10'd0,    1'b1, tsfla_pkg::ST_NO_BUF},
      '{tsfla_pkg::CMD_CHAIN,   32'hFFFFFFFF, 2'd0, 10'd0,    1'b1, tsfla_pkg::ST_NO_BUF},
      '{tsfla_pkg::CMD_RECYCLE, 32'd0,        2'd1, 10'd3,    1'b1, tsfla_pkg::ST_BAD_HDL},
      '{tsfla_pkg::CMD_RECYCLE, 32'd0,        2'd0, 10'd3,    1'b1, tsfla_pkg::ST_IDLE_SL},
      '{tsfla_pkg::CMD_RECYCLE, 32'd0,        2'd0, 10'd0,    1'b0, tsfla_pkg::ST_OK},
      '{tsfla_pkg::CMD_RECYCLE, 32'd0,        2'd3, 10'd1023, 1'b1, tsfla_pkg::ST_IDLE_SL},
      '{tsfla_pkg::CMD_CHAIN,   32'd300,      2'd0, 10'd0,    1'b0, tsfla_pkg::ST_OK},
      '{tsfla_pkg::CMD_CHAIN,   32'd200000,   2'd0, 10'd0,    1'b0, tsfla_pkg::ST_OK},
      '{tsfla_pkg::CMD_ALLOC,   32'd300,      2'd0, 10'd0,    1'b0, tsfla_pkg::ST_OK},
      '{tsfla_pkg::CMD_ALLOC,   32'd2,        2'd0, 10'd0,    1'b0, tsfla_pkg::ST_OK}
    };
    logic [CapW-1:0] b [TierN];
    logic [CntW-1:0] c [TierN];
    int phase_gap [6] = '{0, 46, 0, 20, 46, 20};
    row_t fmt;

    fmt = '{tsfla_pkg::CMD_FORMAT, '0, '0, '0, 1'b0, tsfla_pkg::ST_OK};
    for (int t = 0; t < TierN; t++) begin
      reg_bytes[t] = '0;
      reg_count[t] = '0;
      slice_cap[t] = '0;
      tier_slices[t] = '0;
      head[t] = '0;
      tail[t] = '0;
      free_cnt[t] = 0;
    end
    foreach (in_use[i]) in_use[i] = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    b = '{16'd64, 16'd256, 16'd1024, 16'd65532};
    c = '{11'd4, 11'd3, 11'd2, 11'd1024};
    write_tiers(b, c);
    foreach (dir_rows[i]) send_request(dir_rows[i]);
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          b = '{16'd1000, 16'd200, 16'd65532, 16'd16};
          c = '{11'd5, 11'd1, 11'd1024, 11'd3};
        end
        1: begin
          b = '{16'hFFFF, 16'd0, 16'd8, 16'd4};
          c = '{11'h7FF, 11'd7, 11'd0, 11'd2};
        end
        2: begin
          b = '{16'd4, 16'd8, 16'd12, 16'd16};
          c = '{11'd2, 11'd2, 11'd2, 11'd2};
        end
        default: begin
          for (int t = 0; t < TierN; t++) begin
            b[t] = CapW'($urandom_range(t == 0 ? 0 : 1, 16383) * (t + 1));
            c[t] = $urandom_range(4) == 0 ? CntW'($urandom()) : CntW'($urandom_range(40));
          end
        end
      endcase
      gap_pct = phase_gap[p];
      write_tiers(b, c);
      send_request(fmt);
      for (int i = 0; i < 76; i++) send_request(random_request());
      drain();
    end

    $display("covered %0d requests, %0d granted slices, %0d refused or non-grant results",
             requests_taken, grants_seen, refusals_seen);
    $display("seven tier settings including absent, clamped and out-of-order tiers");
    if (errors == 0) begin
      $display("[tiered_slice_free_list_allocator_unit] OK");
    end else begin
      $display("[tiered_slice_free_list_allocator_unit] ERROR");
    end
    $finish;
  end

endmodule
